### src/wss_pkg.sv
// Shared types, codes and the coil table of the wiper stepper sequencer.
`timescale 1ns / 1ps

package wss_pkg;

    localparam int PERIOD_W  = 16;
    localparam int STROKE_W  = 11;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CHAR_W    = 8;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_START = 2'd1,
        FUNC_STOP  = 2'd2,
        FUNC_LEVEL = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        RUN_STOP_PENDING = 2'd0,
        RUN_ACTIVE       = 2'd1,
        RUN_IDLE         = 2'd2
    } run_status_t;

    typedef enum logic [1:0] {
        REPLY_NONE    = 2'd0,
        REPLY_OK      = 2'd1,
        REPLY_INVALID = 2'd2
    } level_reply_t;

    localparam logic [CFG_IDX_W-1:0] CFG_FAST_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_STROKE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STROKE_END  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_END   = 3'd4;

    localparam logic [PERIOD_W-1:0] FAST_PERIOD_RST = 16'd3;
    localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RST = 16'd6;
    localparam logic [STROKE_W-1:0] HALF_STROKE_RST = 11'd800;
    localparam logic [STROKE_W-1:0] STROKE_END_RST  = 11'd1600;
    localparam logic [STROKE_W-1:0] PAUSE_END_RST   = 11'd1934;

    localparam logic [CHAR_W-1:0] CHAR_LEVEL_ONE   = 8'd49;
    localparam logic [CHAR_W-1:0] CHAR_LEVEL_THREE = 8'd51;

    typedef struct packed {
        logic [STROKE_W-1:0] half_stroke;
        logic [STROKE_W-1:0] stroke_end;
        logic [STROKE_W-1:0] pause_end;
    } stroke_cfg_t;

    typedef struct packed {
        logic [1:0]  phase;
        run_status_t run_status;
        logic        done;
    } sweep_next_t;

    function automatic logic [3:0] coil_pattern(input logic [1:0] phase);
        logic [3:0] pat;
        case (phase)
            2'd0:    pat = 4'h3;
            2'd1:    pat = 4'h6;
            2'd2:    pat = 4'hC;
            default: pat = 4'h9;
        endcase
        return pat;
    endfunction

endpackage

### src/wss_sweep.sv
// Next sweep position for one motor step: forward, return, end of stroke and pause.
`timescale 1ns / 1ps

module wss_sweep
    import wss_pkg::*;
#(
    parameter int COUNT_BITS = 11
) (
    input  logic [COUNT_BITS-1:0] step_count,
    input  logic [1:0]            phase,
    input  run_status_t           run_status,
    input  logic                  level_is_three,
    input  stroke_cfg_t           cfg,
    output logic [COUNT_BITS-1:0] step_next,
    output sweep_next_t           nxt
);

    localparam int CMP_W = (COUNT_BITS > STROKE_W) ? COUNT_BITS : STROKE_W;

    logic [COUNT_BITS-1:0] count_fwd;
    logic [COUNT_BITS-1:0] count_ret;
    logic [1:0]            phase_fwd;
    logic [1:0]            phase_ret;
    logic [CMP_W-1:0]      half_w;
    logic [CMP_W-1:0]      end_w;
    logic [CMP_W-1:0]      pause_w;

    assign half_w  = CMP_W'(cfg.half_stroke);
    assign end_w   = CMP_W'(cfg.stroke_end);
    assign pause_w = CMP_W'(cfg.pause_end);

    always_comb begin
        // Forward half of the sweep.
        if (CMP_W'(step_count) < half_w) begin
            phase_fwd = phase + 2'd1;
            count_fwd = step_count + 1'b1;
        end else begin
            phase_fwd = phase;
            count_fwd = step_count;
        end

        // The return step runs on the freshly advanced count, so the turn
        // step moves forward and back within the same tick.
        if (CMP_W'(count_fwd) >= half_w && CMP_W'(count_fwd) < end_w) begin
            phase_ret = phase_fwd - 2'd1;
            count_ret = count_fwd + 1'b1;
        end else begin
            phase_ret = phase_fwd;
            count_ret = count_fwd;
        end

        nxt.phase      = phase_ret;
        nxt.run_status = run_status;
        nxt.done       = 1'b0;
        step_next      = count_ret;

        if (CMP_W'(count_ret) >= end_w) begin
            nxt.phase = 2'd0;
            if (!level_is_three || CMP_W'(count_ret) == pause_w) begin
                step_next = '0;
            end else begin
                step_next = count_ret + 1'b1;
            end
            if (run_status == RUN_STOP_PENDING) begin
                step_next      = '0;
                nxt.run_status = RUN_IDLE;
                nxt.done       = 1'b1;
            end
        end
    end

endmodule

### src/wiper_stepper_sequencer_top.sv
// Top level of the wiper stepper sequencer: input stage, state, result register.
`timescale 1ns / 1ps

// Wiper stepper sequencer. Every input beat (timer tick, start, stop or level
// character) produces exactly one result beat with the coil drive bits, the
// stopped flag and the level reply. One beat is accepted per clock unless the
// result side holds back; a beat is registered in the input register and its
// result is then registered in the output register, with the sweep state
// updated on its single path as the beat leaves the input register.
// The result register lets the next input be taken while a result waits.
// Configuration registers (0 fast period, 1 slow period, 2 half stroke,
// 3 stroke end, 4 pause end) take effect at once and should be written only
// while no beat is in flight; unknown indexes are ignored.
module wiper_stepper_sequencer_top
    import wss_pkg::*;
#(
    parameter int COUNT_BITS = 11
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_func,
    input  logic [CHAR_W-1:0]    s_level_char,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [3:0]           m_coils,
    output logic                 m_stopped,
    output logic [1:0]           m_level_reply
);

    // Configuration.
    logic [PERIOD_W-1:0] fast_period_reg;
    logic [PERIOD_W-1:0] slow_period_reg;
    stroke_cfg_t         stroke_cfg_reg;

    // Input stage.
    logic              in_valid_reg;
    func_t             in_func_reg;
    logic [CHAR_W-1:0] in_char_reg;

    // Sweep state.
    logic [PERIOD_W-1:0]   tick_count_reg,  tick_count_next;
    logic [1:0]            phase_reg,       phase_next;
    logic [COUNT_BITS-1:0] step_count_reg,  step_count_next;
    run_status_t           run_status_reg,  run_status_next;
    logic                  level_three_reg, level_three_next;
    logic                  use_fast_reg,    use_fast_next;
    logic [3:0]            coil_latch_reg,  coil_latch_next;

    // Result register.
    logic         out_valid_reg;
    logic [3:0]   out_coils_reg;
    logic         out_stopped_reg;
    level_reply_t out_reply_reg;

    logic                  advance;
    logic                  stopped_next;
    level_reply_t          reply_next;
    logic [PERIOD_W-1:0]   tick_inc;
    logic [PERIOD_W-1:0]   period;
    logic [COUNT_BITS-1:0] sweep_step;
    sweep_next_t           sweep;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fast_period_reg <= FAST_PERIOD_RST;
            slow_period_reg <= SLOW_PERIOD_RST;
            stroke_cfg_reg  <= '{HALF_STROKE_RST, STROKE_END_RST, PAUSE_END_RST};
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_FAST_PERIOD: fast_period_reg            <= cfg_wdata;
                CFG_SLOW_PERIOD: slow_period_reg            <= cfg_wdata;
                CFG_HALF_STROKE: stroke_cfg_reg.half_stroke <= cfg_wdata[STROKE_W-1:0];
                CFG_STROKE_END:  stroke_cfg_reg.stroke_end  <= cfg_wdata[STROKE_W-1:0];
                CFG_PAUSE_END:   stroke_cfg_reg.pause_end   <= cfg_wdata[STROKE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_func_reg <= func_t'(s_func);
            in_char_reg <= s_level_char;
        end
    end

    wss_sweep #(
        .COUNT_BITS (COUNT_BITS)
    ) u_sweep (
        .step_count     (step_count_reg),
        .phase          (phase_reg),
        .run_status     (run_status_reg),
        .level_is_three (level_three_reg),
        .cfg            (stroke_cfg_reg),
        .step_next      (sweep_step),
        .nxt            (sweep)
    );

    assign tick_inc = tick_count_reg + 1'b1;
    assign period   = use_fast_reg ? fast_period_reg : slow_period_reg;

    always_comb begin
        tick_count_next  = tick_count_reg;
        phase_next       = phase_reg;
        step_count_next  = step_count_reg;
        run_status_next  = run_status_reg;
        level_three_next = level_three_reg;
        use_fast_next    = use_fast_reg;
        coil_latch_next  = coil_latch_reg;
        stopped_next     = 1'b0;
        reply_next       = REPLY_NONE;

        case (in_func_reg)
            FUNC_TICK: begin
                tick_count_next = tick_inc;
                // While idle the prescaler free-runs and never clears.
                if (tick_inc >= period && run_status_reg != RUN_IDLE) begin
                    tick_count_next = '0;
                    coil_latch_next = coil_pattern(phase_reg);
                    phase_next      = sweep.phase;
                    step_count_next = sweep_step;
                    run_status_next = sweep.run_status;
                    stopped_next    = sweep.done;
                end
            end
            FUNC_START: run_status_next = RUN_ACTIVE;
            FUNC_STOP:  run_status_next = RUN_STOP_PENDING;
            FUNC_LEVEL: begin
                level_three_next = (in_char_reg == CHAR_LEVEL_THREE);
                if (in_char_reg inside {[CHAR_LEVEL_ONE:CHAR_LEVEL_THREE]}) begin
                    use_fast_next = (in_char_reg == CHAR_LEVEL_ONE);
                    reply_next    = REPLY_OK;
                end else begin
                    reply_next    = REPLY_INVALID;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg  <= '0;
            phase_reg       <= 2'd0;
            step_count_reg  <= '0;
            run_status_reg  <= RUN_IDLE;
            level_three_reg <= 1'b0;
            use_fast_reg    <= 1'b0;
            coil_latch_reg  <= 4'h0;
        end else if (advance) begin
            tick_count_reg  <= tick_count_next;
            phase_reg       <= phase_next;
            step_count_reg  <= step_count_next;
            run_status_reg  <= run_status_next;
            level_three_reg <= level_three_next;
            use_fast_reg    <= use_fast_next;
            coil_latch_reg  <= coil_latch_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_coils_reg   <= coil_latch_next;
            out_stopped_reg <= stopped_next;
            out_reply_reg   <= reply_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_coils       = out_coils_reg;
    assign m_stopped     = out_stopped_reg;
    assign m_level_reply = out_reply_reg;

`ifndef SYNTHESIS
    // An idle wiper always sits parked at the start of the sweep.
    a_idle_parked: assert property (@(posedge aclk) disable iff (!aresetn)
        run_status_reg == RUN_IDLE |-> step_count_reg == '0 && phase_reg == 2'd0)
        else $error("idle wiper is not parked");

    // A stopped flag that is still on offer belongs to the latest state update.
    a_stopped_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_stopped_reg |-> run_status_reg == RUN_IDLE)
        else $error("stopped reported while the wiper is not idle");

    // Every beat that leaves the input stage lands in the result register.
    a_advance_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("result lost after the input stage advanced");
`endif

endmodule

### tb/wiper_stepper_sequencer_top_tb.sv
// Self-checking testbench for the wiper stepper sequencer: stimulus, prediction and checks.
`timescale 1ns / 1ps

module wiper_stepper_sequencer_top_tb;
    import wss_pkg::*;

    localparam int COUNT_BITS = 11;
    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD = 400;
    localparam int HOLD_AT = 200;
    // Coil patterns for phases 0 to 3, phase 0 in the low nibble.
    localparam logic [15:0] COIL_SEQ = 16'h9C63;

    typedef struct packed {
        func_t             op;
        logic [CHAR_W-1:0] ch;
    } cmd_beat_t;

    typedef struct packed {
        logic [3:0]   coils;
        logic         stopped;
        level_reply_t reply;
    } sweep_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_func = FUNC_TICK;
    logic [CHAR_W-1:0]    s_level_char = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [3:0]           m_coils;
    logic                 m_stopped;
    logic [1:0]           m_level_reply;

    // Predicted sequencer state and register copies.
    logic [PERIOD_W-1:0]   fast_ticks = FAST_PERIOD_RST;
    logic [PERIOD_W-1:0]   slow_ticks = SLOW_PERIOD_RST;
    logic [STROKE_W-1:0]   turn_at = HALF_STROKE_RST;
    logic [STROKE_W-1:0]   sweep_end = STROKE_END_RST;
    logic [STROKE_W-1:0]   pause_at = PAUSE_END_RST;
    logic [PERIOD_W-1:0]   prescale = '0;
    logic [1:0]            coil_phase = '0;
    logic [COUNT_BITS-1:0] sweep_pos = '0;
    run_status_t           status = RUN_IDLE;
    logic                  third_level = 1'b0;
    logic                  fast_sel = 1'b0;
    logic [3:0]            coil_hold = '0;

    cmd_beat_t     pending_beats[$];
    sweep_result_t expected_results[$];
    cmd_beat_t     next_beat;
    sweep_result_t want;
    int unsigned   beats_queued = 0;
    int unsigned   beats_sent = 0;
    int unsigned   results_done = 0;
    int unsigned   mismatches = 0;
    int unsigned   stall_cycles = 0;
    int unsigned   send_gap = 0;
    int unsigned   ready_gap = 0;
    int unsigned   in_calm = 0;
    int unsigned   out_calm = 0;
    bit            in_taken = 1'b0;
    bit            out_taken = 1'b0;

    wiper_stepper_sequencer_top #(
        .COUNT_BITS(COUNT_BITS)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_level_char (s_level_char),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_coils      (m_coils),
        .m_stopped    (m_stopped),
        .m_level_reply(m_level_reply)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Advances the predicted state by one command and returns the result it causes.
    function automatic sweep_result_t sweep_predict(input func_t op,
                                                    input logic [CHAR_W-1:0] ch);
        sweep_result_t       res;
        logic [PERIOD_W-1:0] per;
        res.coils = '0;
        res.stopped = 1'b0;
        res.reply = REPLY_NONE;
        case (op)
            FUNC_TICK: begin
                per = fast_sel ? fast_ticks : slow_ticks;
                prescale = prescale + 1'b1;
                if (prescale >= per && status != RUN_IDLE) begin
                    prescale = '0;
                    coil_hold = COIL_SEQ[coil_phase * 4 +: 4];
                    if (sweep_pos < turn_at) begin
                        coil_phase = coil_phase + 2'd1;
                        sweep_pos = sweep_pos + 1'b1;
                    end
                    // The return leg may follow the last forward step in the same tick.
                    if (sweep_pos >= turn_at && sweep_pos < sweep_end) begin
                        coil_phase = coil_phase - 2'd1;
                        sweep_pos = sweep_pos + 1'b1;
                    end
                    if (sweep_pos >= sweep_end) begin
                        coil_phase = '0;
                        if (!third_level || sweep_pos == pause_at)
                            sweep_pos = '0;
                        else
                            sweep_pos = sweep_pos + 1'b1;
                        if (status == RUN_STOP_PENDING) begin
                            sweep_pos = '0;
                            status = RUN_IDLE;
                            res.stopped = 1'b1;
                        end
                    end
                end
            end
            FUNC_START: status = RUN_ACTIVE;
            FUNC_STOP:  status = RUN_STOP_PENDING;
            default: begin
                third_level = (ch == CHAR_LEVEL_THREE);
                if (ch >= CHAR_LEVEL_ONE && ch <= CHAR_LEVEL_THREE) begin
                    fast_sel = (ch == CHAR_LEVEL_ONE);
                    res.reply = REPLY_OK;
                end else begin
                    res.reply = REPLY_INVALID;
                end
            end
        endcase
        res.coils = coil_hold;
        return res;
    endfunction

    function automatic int unsigned pick_gap(input bit calm);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic queue_beat(input func_t op, input logic [CHAR_W-1:0] ch);
        cmd_beat_t b;
        b.op = op;
        b.ch = ch;
        pending_beats.push_back(b);
        beats_queued++;
    endtask

    task automatic queue_ticks(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            queue_beat(FUNC_TICK, CHAR_W'($urandom_range(0, 255)));
    endtask

    // Mostly ticks so that sweeps complete, with starts, stops and level bytes mixed in.
    task automatic queue_sweep_traffic(input int unsigned n);
        int unsigned roll;
        for (int unsigned i = 0; i < n; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 88)
                queue_beat(FUNC_TICK, CHAR_W'($urandom_range(0, 255)));
            else if (roll < 91)
                queue_beat(FUNC_START, CHAR_W'($urandom_range(0, 255)));
            else if (roll < 94)
                queue_beat(FUNC_STOP, CHAR_W'($urandom_range(0, 255)));
            else if (roll < 98)
                queue_beat(FUNC_LEVEL, CHAR_W'(CHAR_LEVEL_ONE + $urandom_range(0, 2)));
            else
                queue_beat(FUNC_LEVEL, CHAR_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr = idx;
        cfg_wdata = val;
        case (idx)
            CFG_FAST_PERIOD: fast_ticks = val;
            CFG_SLOW_PERIOD: slow_ticks = val;
            CFG_HALF_STROKE: turn_at = val[STROKE_W-1:0];
            CFG_STROKE_END:  sweep_end = val[STROKE_W-1:0];
            CFG_PAUSE_END:   pause_at = val[STROKE_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic write_all(input logic [CFG_W-1:0] fast, input logic [CFG_W-1:0] slow,
                             input logic [CFG_W-1:0] half, input logic [CFG_W-1:0] stop_at,
                             input logic [CFG_W-1:0] pause);
        reg_write(CFG_FAST_PERIOD, fast);
        reg_write(CFG_SLOW_PERIOD, slow);
        reg_write(CFG_HALF_STROKE, half);
        reg_write(CFG_STROKE_END, stop_at);
        reg_write(CFG_PAUSE_END, pause);
    endtask

    // Returns once every queued beat has been taken and answered, then waits a little longer.
    task automatic wait_drained();
        while (beats_sent != beats_queued || expected_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        int unsigned half;
        int unsigned stop_at;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // While idle the prescaler keeps counting and never clears, so the first
        // tick after the start steps at once.
        write_all(16'd4, 16'd4, HALF_STROKE_RST, STROKE_END_RST, PAUSE_END_RST);
        queue_ticks(10);
        queue_beat(FUNC_START, 8'h00);
        queue_ticks(2);
        queue_beat(FUNC_STOP, 8'hFF);
        wait_drained();

        // Directed part on a short stroke.
        write_all(16'd1, 16'd1, 16'd2, 16'd4, 16'd6);
        queue_ticks(6);
        queue_ticks(2);
        queue_beat(FUNC_LEVEL, 8'h00);
        queue_beat(FUNC_LEVEL, 8'hFF);
        queue_beat(FUNC_LEVEL, CHAR_LEVEL_ONE - 1'b1);
        queue_beat(FUNC_LEVEL, CHAR_LEVEL_THREE + 1'b1);
        queue_beat(FUNC_LEVEL, CHAR_LEVEL_ONE + 1'b1);
        queue_beat(FUNC_LEVEL, CHAR_LEVEL_THREE);
        queue_beat(FUNC_LEVEL, CHAR_LEVEL_ONE);
        queue_beat(FUNC_STOP, 8'h55);
        queue_ticks(6);
        queue_beat(FUNC_START, 8'hAA);
        queue_beat(FUNC_STOP, 8'h00);
        queue_beat(FUNC_START, 8'hFF);
        queue_ticks(4);
        wait_drained();

        // Upper register bits must be dropped and unused indexes ignored.
        write_all(16'd1, 16'd2, 16'hF803, 16'h0806, 16'd9);
        for (int unsigned i = CFG_PAUSE_END + 1; i < (1 << CFG_IDX_W); i++)
            reg_write(i[CFG_IDX_W-1:0], CFG_W'($urandom_range(0, 16'hFFFF)));
        queue_sweep_traffic(200);
        wait_drained();

        for (int unsigned k = 0; k < 5; k++) begin
            half = $urandom_range(1, 6);
            stop_at = half + $urandom_range(1, 6);
            write_all(CFG_W'($urandom_range(0, 3)), CFG_W'($urandom_range(0, 4)),
                      CFG_W'(half), CFG_W'(stop_at),
                      CFG_W'(stop_at + $urandom_range(0, 6)));
            queue_sweep_traffic(90);
            wait_drained();
        end

        // A pause end below the stroke end lets the count run on past the stroke end.
        write_all(16'd1, 16'd0, 16'd1, 16'd3, 16'd2);
        queue_beat(FUNC_LEVEL, CHAR_LEVEL_THREE);
        queue_beat(FUNC_START, 8'h00);
        queue_ticks(200);
        queue_beat(FUNC_STOP, 8'h00);
        queue_ticks(20);
        wait_drained();

        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Beat driver.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_beats.size() != 0) begin
                next_beat = pending_beats.pop_front();
                s_func <= next_beat.op;
                s_level_char <= next_beat.ch;
                s_valid <= 1'b1;
                if (in_calm > 0)
                    in_calm--;
                else if ($urandom_range(0, 99) == 0)
                    in_calm = $urandom_range(20, 80);
                send_gap = pick_gap(in_calm != 0);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver; one long hold-off lets the block back up into its input.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (out_taken) begin
                if (results_done == HOLD_AT) begin
                    ready_gap = LONG_HOLD;
                end else begin
                    if (out_calm > 0)
                        out_calm--;
                    else if ($urandom_range(0, 99) == 0)
                        out_calm = $urandom_range(20, 80);
                    ready_gap = pick_gap(out_calm != 0);
                end
            end else if (ready_gap == 0 && out_calm == 0 && $urandom_range(0, 15) == 0) begin
                ready_gap = $urandom_range(1, 4);
            end
            if (ready_gap > 0) begin
                ready_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Monitor: predicts on each input beat, checks each result beat, and watches for hangs.
    always @(posedge aclk) begin
        in_taken = aresetn && s_valid && s_ready;
        out_taken = aresetn && m_valid && m_ready;
        if (in_taken) begin
            expected_results.push_back(sweep_predict(func_t'(s_func), s_level_char));
            beats_sent++;
        end
        if (out_taken) begin
            results_done++;
            if (expected_results.size() == 0) begin
                $error("result beat arrived with nothing expected");
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (m_coils !== want.coils) begin
                    $error("coils: expected %h, actual %h", want.coils, m_coils);
                    mismatches++;
                end
                if (m_stopped !== want.stopped) begin
                    $error("stopped: expected %b, actual %b", want.stopped, m_stopped);
                    mismatches++;
                end
                if (m_level_reply !== want.reply) begin
                    $error("level_reply: expected %0d, actual %0d", want.reply, m_level_reply);
                    mismatches++;
                end
            end
        end
        if (in_taken || out_taken)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

endmodule

### files.f
src/wss_pkg.sv
src/wss_sweep.sv
src/wiper_stepper_sequencer_top.sv
tb/wiper_stepper_sequencer_top_tb.sv
